FILE: design/cdq_pkg.sv
// shared types and constants of the circular deque
`default_nettype none

package cdq_pkg;

   // default ring depth and widest supported ring address
   localparam int DepthDefault = 64;
   localparam int AddrW        = 6;
   localparam int WordW        = 32;

   // request codes
   typedef enum logic [2:0] {
      REQ_PUSH_HEAD = 3'd0,
      REQ_PUSH_TAIL = 3'd1,
      REQ_POP_HEAD  = 3'd2,
      REQ_POP_TAIL  = 3'd3,
      REQ_DUMP      = 3'd4
   } req_code_type;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   // control sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_DUMP
   } state_type;

   // ring memory request: write port and read port fields
   typedef struct packed {
      logic             wr_en;
      logic [AddrW-1:0] wr_addr;
      logic [WordW-1:0] wr_data;
      logic             rd_en;
      logic [AddrW-1:0] rd_addr;
   } ram_req_type;

endpackage

`default_nettype wire

FILE: design/circular_deque.sv
// top level of the circular deque: request sequencer, indices and result register
`default_nettype none

// Double-ended queue of DEPTH signed 32-bit words held in a ring memory with a
// registered read. A push gives its result word in the output register
// straight away; a pop issues the memory read when it is taken and gives its
// word from the ST_POP state. A dump starts the read of the head entry and
// then streams one stored word per cycle from head to tail, the final one
// marked with rsp_last, for as long as the result side takes them. One request
// is worked on at a time, and a new request is taken only once the result
// register is free or being emptied in that cycle. Unused request codes are
// taken and give no result. No clearing pass is needed after reset.
module circular_deque #(
   parameter int DEPTH = cdq_pkg::DepthDefault
) (
   input  wire                clock,
   input  wire                reset,
   // request channel
   input  wire                req_valid,
   output logic               req_stall,
   input  wire         [2:0]  req_type,
   input  wire  signed [31:0] req_push_value,
   // result channel
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic        [1:0]  rsp_status,
   output logic signed [31:0] rsp_read_value,
   output logic               rsp_last
);

   localparam int IdxW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam logic [IdxW-1:0] LastSlot = IdxW'(DEPTH - 1);

   cdq_pkg::state_type          state_ff, state_in;
   logic [IdxW-1:0]             head_ff, head_in;
   logic [IdxW-1:0]             tail_ff, tail_in;
   logic                        holds_ff, holds_in;
   logic [IdxW-1:0]             dmp_idx_ff, dmp_idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [1:0]                  rsp_status_ff, rsp_status_in;
   logic [31:0]                 rsp_value_ff, rsp_value_in;
   logic                        rsp_last_ff, rsp_last_in;

   cdq_pkg::ram_req_type        ram_req;
   logic [cdq_pkg::WordW-1:0]   rd_data;

   logic                        out_free;
   logic                        accept;
   logic                        full;
   logic                        dmp_end;

   // ring index stepping with wrap
   function automatic logic [IdxW-1:0] slot_next(input logic [IdxW-1:0] i);
      slot_next = (i == LastSlot) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IdxW-1:0] slot_prev(input logic [IdxW-1:0] i);
      slot_prev = (i == '0) ? LastSlot : i - 1'b1;
   endfunction

   // ring memory; only one access per cycle, a write always lands before any read of it
   cdq_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .ram_req(ram_req),
      .rd_data(rd_data)
   );

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == cdq_pkg::ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign full      = holds_ff && (slot_next(tail_ff) == head_ff);
   assign dmp_end   = (dmp_idx_ff == tail_ff);

   // sequencer next state, index updates and result word
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      holds_in      = holds_ff;
      dmp_idx_in    = dmp_idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      ram_req       = '0;

      unique case (state_ff)
         cdq_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (cdq_pkg::req_code_type'(req_type))
                  cdq_pkg::REQ_PUSH_HEAD, cdq_pkg::REQ_PUSH_TAIL: begin
                     rsp_valid_in = 1'b1;
                     rsp_value_in = '0;
                     rsp_last_in  = 1'b1;
                     if (full) begin
                        rsp_status_in = cdq_pkg::STATUS_OVERFLOW;
                     end else begin
                        rsp_status_in   = cdq_pkg::STATUS_OK;
                        ram_req.wr_en   = 1'b1;
                        ram_req.wr_data = req_push_value;
                        if (!holds_ff) begin
                           // first item lands in slot zero
                           head_in         = '0;
                           tail_in         = '0;
                           holds_in        = 1'b1;
                           ram_req.wr_addr = '0;
                        end else if (req_type == cdq_pkg::REQ_PUSH_HEAD) begin
                           head_in         = slot_prev(head_ff);
                           ram_req.wr_addr = cdq_pkg::AddrW'(slot_prev(head_ff));
                        end else begin
                           tail_in         = slot_next(tail_ff);
                           ram_req.wr_addr = cdq_pkg::AddrW'(slot_next(tail_ff));
                        end
                     end
                  end
                  cdq_pkg::REQ_POP_HEAD, cdq_pkg::REQ_POP_TAIL: begin
                     if (!holds_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = cdq_pkg::STATUS_EMPTY;
                        rsp_value_in  = '1;
                        rsp_last_in   = 1'b1;
                     end else begin
                        ram_req.rd_en = 1'b1;
                        state_in      = cdq_pkg::ST_POP;
                        if (req_type == cdq_pkg::REQ_POP_HEAD) begin
                           ram_req.rd_addr = cdq_pkg::AddrW'(head_ff);
                        end else begin
                           ram_req.rd_addr = cdq_pkg::AddrW'(tail_ff);
                        end
                        // indices move now, the read uses the old slot
                        if (head_ff == tail_ff) begin
                           holds_in = 1'b0;
                        end else if (req_type == cdq_pkg::REQ_POP_HEAD) begin
                           head_in = slot_next(head_ff);
                        end else begin
                           tail_in = slot_prev(tail_ff);
                        end
                     end
                  end
                  cdq_pkg::REQ_DUMP: begin
                     if (!holds_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = cdq_pkg::STATUS_EMPTY;
                        rsp_value_in  = '0;
                        rsp_last_in   = 1'b1;
                     end else begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = cdq_pkg::AddrW'(head_ff);
                        dmp_idx_in      = head_ff;
                        state_in        = cdq_pkg::ST_DUMP;
                     end
                  end
                  default: begin
                     // unused codes: taken, no result
                  end
               endcase
            end
         end
         cdq_pkg::ST_POP: begin
            // result register is free: it was free when the pop was taken
            rsp_valid_in  = 1'b1;
            rsp_status_in = cdq_pkg::STATUS_OK;
            rsp_value_in  = rd_data;
            rsp_last_in   = 1'b1;
            state_in      = cdq_pkg::ST_IDLE;
         end
         cdq_pkg::ST_DUMP: begin
            // stream one word per cycle while the result register is free, next read issued as this one is taken
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = cdq_pkg::STATUS_OK;
               rsp_value_in  = rd_data;
               rsp_last_in   = dmp_end;
               if (dmp_end) begin
                  state_in = cdq_pkg::ST_IDLE;
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = cdq_pkg::AddrW'(slot_next(dmp_idx_ff));
                  dmp_idx_in      = slot_next(dmp_idx_ff);
               end
            end
         end
         default: begin
            state_in = cdq_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdq_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         holds_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         holds_ff     <= holds_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dmp_idx_ff    <= dmp_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

FILE: design/cdq_ram.sv
// ring storage: one write port, one read port with registered read data
`default_nettype none

module cdq_ram #(
   parameter int DEPTH = cdq_pkg::DepthDefault
) (
   input  wire                       clock,
   input  cdq_pkg::ram_req_type      ram_req,
   output logic [cdq_pkg::WordW-1:0] rd_data
);

   localparam int IdxW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

   logic [cdq_pkg::WordW-1:0] mem_ff [DEPTH];
   logic [cdq_pkg::WordW-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem_ff[ram_req.wr_addr[IdxW-1:0]] <= ram_req.wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem_ff[ram_req.rd_addr[IdxW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/cdq_checker.sv
// port-level checks of the circular deque, bound to the top level
`default_nettype none

module cdq_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [1:0]  rsp_status,
   input wire [31:0] rsp_read_value,
   input wire        rsp_last
);

   // no result word straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // a stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_status) && $stable(rsp_read_value) && $stable(rsp_last))
      else $error("stalled result word changed");

   // overflow and empty answers are single final words
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == cdq_pkg::STATUS_OVERFLOW ||
                    rsp_status == cdq_pkg::STATUS_EMPTY) |-> rsp_last)
      else $error("error status on a non-final word");

   // a refused push carries a zero value
   a_over_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cdq_pkg::STATUS_OVERFLOW |-> rsp_read_value == '0)
      else $error("overflow word with non-zero value");

   // the empty answer is -1 for a pop or 0 for a dump, nothing else
   a_empty_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cdq_pkg::STATUS_EMPTY |->
         rsp_read_value == '0 || rsp_read_value == '1)
      else $error("empty word with unexpected value");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_status    (rsp_status),
   .rsp_read_value(rsp_read_value),
   .rsp_last      (rsp_last)
);

`default_nettype wire

FILE: tb/sv/tb_circular_deque.sv
// self-checking testbench of the circular deque, with its own prediction of every result word
`timescale 1ns / 100ps

module tb_circular_deque;

   localparam int DEPTH = cdq_pkg::DepthDefault;
   // request codes that the block takes and drops without a result
   localparam logic [2:0] REQ_SPARE_5 = 3'd5;
   localparam logic [2:0] REQ_SPARE_6 = 3'd6;
   localparam logic [2:0] REQ_SPARE_7 = 3'd7;
   localparam logic signed [31:0] WORD_MINUS_ONE = -32'sd1;
   localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
   localparam int IDLE_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 20;
   localparam int MISMATCH_SHOWN = 10;

   typedef struct packed {
      cdq_pkg::status_type status;
      logic signed [31:0]  value;
      logic                last;
   } result_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid;
   logic req_stall;
   logic [2:0] req_type;
   logic signed [31:0] req_push_value;
   logic rsp_valid;
   logic rsp_stall;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_read_value;
   logic rsp_last;

   // mirror of the deque contents and indices
   logic [31:0] ring_mirror [DEPTH];
   logic [5:0] head_slot;
   logic [5:0] tail_slot;
   bit holding;
   int occupancy;

   result_word_type pending_results[$];
   bit calm;
   int mismatches;
   int requests_sent;
   int words_checked;
   int overflows;
   int underflows;
   int full_dumps;
   int quiet_cycles;

   circular_deque #(.DEPTH(DEPTH)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_last       (rsp_last)
   );

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [5:0] next_slot(input logic [5:0] slot);
      return (slot == DEPTH - 1) ? 6'd0 : slot + 6'd1;
   endfunction

   function automatic logic [5:0] prev_slot(input logic [5:0] slot);
      return (slot == 6'd0) ? 6'(DEPTH - 1) : slot - 6'd1;
   endfunction

   function automatic void expect_word(input cdq_pkg::status_type status,
                                       input logic [31:0] value, input logic last);
      result_word_type w;
      w.status = status;
      w.value = value;
      w.last = last;
      pending_results.push_back(w);
   endfunction

   // work out the result words of one accepted request and update the mirror
   function automatic void deque_predict(input logic [2:0] code, input logic [31:0] value);
      logic [5:0] slot;
      bit full_now;
      bit final_word;
      full_now = holding && next_slot(tail_slot) == head_slot;
      case (code)
         cdq_pkg::REQ_PUSH_HEAD, cdq_pkg::REQ_PUSH_TAIL: begin
            if (full_now) begin
               overflows++;
               expect_word(cdq_pkg::STATUS_OVERFLOW, 32'd0, 1'b1);
            end else begin
               if (!holding) begin
                  head_slot = 6'd0;
                  tail_slot = 6'd0;
                  holding = 1'b1;
                  ring_mirror[0] = value;
               end else if (code == cdq_pkg::REQ_PUSH_HEAD) begin
                  head_slot = prev_slot(head_slot);
                  ring_mirror[head_slot] = value;
               end else begin
                  tail_slot = next_slot(tail_slot);
                  ring_mirror[tail_slot] = value;
               end
               occupancy++;
               expect_word(cdq_pkg::STATUS_OK, 32'd0, 1'b1);
            end
         end
         cdq_pkg::REQ_POP_HEAD, cdq_pkg::REQ_POP_TAIL: begin
            if (!holding) begin
               underflows++;
               expect_word(cdq_pkg::STATUS_EMPTY, WORD_MINUS_ONE, 1'b1);
            end else begin
               slot = (code == cdq_pkg::REQ_POP_HEAD) ? head_slot : tail_slot;
               expect_word(cdq_pkg::STATUS_OK, ring_mirror[slot], 1'b1);
               if (head_slot == tail_slot)
                  holding = 1'b0;
               else if (code == cdq_pkg::REQ_POP_HEAD)
                  head_slot = next_slot(head_slot);
               else
                  tail_slot = prev_slot(tail_slot);
               occupancy--;
            end
         end
         cdq_pkg::REQ_DUMP: begin
            if (!holding) begin
               expect_word(cdq_pkg::STATUS_EMPTY, 32'd0, 1'b1);
            end else begin
               if (occupancy == DEPTH)
                  full_dumps++;
               slot = head_slot;
               for (int k = 0; k < DEPTH; k++) begin
                  final_word = (slot == tail_slot) || (k == DEPTH - 1);
                  expect_word(cdq_pkg::STATUS_OK, ring_mirror[slot], final_word);
                  if (final_word)
                     break;
                  slot = next_slot(slot);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // offer one request word, with random idle cycles ahead of it unless calm, and wait for acceptance
   task automatic send_request(input logic [2:0] code, input logic signed [31:0] value);
      while (!calm && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= code;
      req_push_value <= value;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      deque_predict(code, value);
      if (code <= cdq_pkg::REQ_DUMP)
         requests_sent++;
   endtask

   function automatic logic [2:0] random_push();
      return $urandom_range(1) ? cdq_pkg::REQ_PUSH_TAIL : cdq_pkg::REQ_PUSH_HEAD;
   endfunction

   function automatic logic [2:0] random_pop();
      return $urandom_range(1) ? cdq_pkg::REQ_POP_TAIL : cdq_pkg::REQ_POP_HEAD;
   endfunction

   // requests on an empty deque, and the spare codes
   task automatic test_empty_requests();
      send_request(cdq_pkg::REQ_POP_HEAD, WORD_MAX);
      send_request(cdq_pkg::REQ_POP_TAIL, WORD_MIN);
      send_request(cdq_pkg::REQ_DUMP, WORD_MINUS_ONE);
      send_request(REQ_SPARE_5, WORD_MAX);
      send_request(REQ_SPARE_6, 32'sd0);
      send_request(REQ_SPARE_7, WORD_MINUS_ONE);
   endtask

   // extremes of the word, head wrap below slot 0, pops down to the only item and one pop past it
   task automatic test_push_pop_basics();
      send_request(cdq_pkg::REQ_PUSH_HEAD, WORD_MAX);
      send_request(cdq_pkg::REQ_PUSH_TAIL, WORD_MIN);
      send_request(cdq_pkg::REQ_PUSH_HEAD, WORD_MINUS_ONE);
      send_request(cdq_pkg::REQ_PUSH_TAIL, 32'sd0);
      send_request(cdq_pkg::REQ_PUSH_HEAD, 32'sh5555_5555);
      send_request(cdq_pkg::REQ_PUSH_TAIL, 32'shAAAA_AAAA);
      send_request(cdq_pkg::REQ_DUMP, 32'sd0);
      send_request(cdq_pkg::REQ_POP_HEAD, 32'sd0);
      send_request(cdq_pkg::REQ_POP_TAIL, 32'sd0);
      send_request(cdq_pkg::REQ_POP_HEAD, 32'sd0);
      send_request(cdq_pkg::REQ_POP_TAIL, 32'sd0);
      send_request(cdq_pkg::REQ_POP_HEAD, 32'sd0);
      send_request(cdq_pkg::REQ_POP_TAIL, 32'sd0);
      send_request(cdq_pkg::REQ_POP_TAIL, 32'sd0);
   endtask

   // fill to full, push against the full ring, dump it, rotate eight entries, dump again, drain, pop once more
   task automatic test_fill_and_drain();
      while (occupancy < DEPTH)
         send_request(random_push(), $urandom());
      send_request(cdq_pkg::REQ_PUSH_HEAD, $urandom());
      send_request(cdq_pkg::REQ_PUSH_TAIL, $urandom());
      send_request(cdq_pkg::REQ_DUMP, $urandom());
      repeat (8) begin
         send_request(cdq_pkg::REQ_POP_HEAD, $urandom());
         send_request(cdq_pkg::REQ_PUSH_TAIL, $urandom());
      end
      send_request(cdq_pkg::REQ_DUMP, $urandom());
      while (occupancy > 0)
         send_request(random_pop(), $urandom());
      send_request(random_pop(), $urandom());
   endtask

   // free mix of every request type with random words
   task automatic test_random_mix(input int count);
      int pick;
      logic [2:0] code;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 26)
            code = cdq_pkg::REQ_PUSH_HEAD;
         else if (pick < 52)
            code = cdq_pkg::REQ_PUSH_TAIL;
         else if (pick < 72)
            code = cdq_pkg::REQ_POP_HEAD;
         else if (pick < 92)
            code = cdq_pkg::REQ_POP_TAIL;
         else if (pick < 98)
            code = cdq_pkg::REQ_DUMP;
         else
            code = 3'($urandom_range(REQ_SPARE_5, REQ_SPARE_7));
         send_request(code, $urandom());
      end
   endtask

   // result side back-pressure
   always @(posedge clock)
      rsp_stall <= !calm && ($urandom_range(99) < 26);

   // compare each accepted result word with the oldest prediction
   always @(posedge clock) begin : check_results
      result_word_type got;
      result_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.status = cdq_pkg::status_type'(rsp_status);
         got.value = rsp_read_value;
         got.last = rsp_last;
         words_checked++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN)
               $display("unexpected word: status %0d value %0d last %0b",
                        got.status, got.value, got.last);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MISMATCH_SHOWN)
                  $display("mismatch at %0t: expected status %0d value %0d last %0b, got %0d %0d %0b",
                           $realtime, want.status, want.value, want.last,
                           rsp_status, rsp_read_value, rsp_last);
            end
         end
      end
   end

   // watchdog on cycles with nothing accepted while work is outstanding
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else if (req_valid || pending_results.size() != 0)
         quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout: no word accepted in %0d cycles", IDLE_LIMIT);
         $display("tb_circular_deque NOT OK");
         $finish;
      end
   end

   initial begin
      req_valid <= 1'b0;
      req_type <= cdq_pkg::REQ_DUMP;
      req_push_value <= 32'sd0;
      calm = 1'b0;
      holding = 1'b0;
      head_slot = 6'd0;
      tail_slot = 6'd0;
      occupancy = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_requests();
      test_push_pop_basics();
      test_fill_and_drain();
      // long stretch with no idling on either side
      calm = 1'b1;
      test_fill_and_drain();
      calm = 1'b0;
      test_random_mix(150);
      req_valid <= 1'b0;

      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests and %0d result words: %0d overflows, %0d underflows,",
               requests_sent, words_checked, overflows, underflows);
      $display("%0d dumps of a full ring, %0d mismatches", full_dumps, mismatches);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("tb_circular_deque OK");
      else
         $display("tb_circular_deque NOT OK");
      $finish;
   end

endmodule

FILE: filelist.f
design/cdq_pkg.sv
design/cdq_ram.sv
design/circular_deque.sv
design/cdq_checker.sv
tb/sv/tb_circular_deque.sv
